/* design/fdr_pkg.sv */
// Shared constants, lane types and output item type for the Fresnel reflectance pipeline.
package fdr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COS_W      = 18;
  localparam int ETA_W      = 20;
  localparam int REFL_W     = 17;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 32;

  // Divider lane: remainder and divisor width, quotient width.
  localparam int DW = 56;
  localparam int QW = 33;
  // Square root lane: remainder width.
  localparam int RW = 36;

  localparam logic [REFL_W-1:0] REFL_ONE = REFL_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [31:0]   root;
    logic [31:0]   rad;
  } sqrt_lane_t;

  typedef struct packed {
    logic [REFL_W-1:0] refl;
    logic              tir;
  } out_item_t;

endpackage

/* design/fdr_div_cell.sv */
// One restoring division step with its lane register.
module fdr_div_cell (
  input  logic              clk,
  input  logic              en,
  input  fdr_pkg::div_lane_t lane_in,
  output fdr_pkg::div_lane_t lane_r
);
  import fdr_pkg::*;

  logic [DW-1:0] rem_sh;
  logic          take;
  div_lane_t     lane_nxt;

  always_comb begin
    rem_sh        = {lane_in.rem[DW-2:0], 1'b0};
    take          = rem_sh >= lane_in.den;
    lane_nxt.den  = lane_in.den;
    lane_nxt.rem  = take ? rem_sh - lane_in.den : rem_sh;
    lane_nxt.quo  = {lane_in.quo[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

/* design/fdr_sqrt_cell.sv */
// One digit-by-digit square root step with its lane register.
module fdr_sqrt_cell (
  input  logic               clk,
  input  logic               en,
  input  fdr_pkg::sqrt_lane_t lane_in,
  output fdr_pkg::sqrt_lane_t lane_r
);
  import fdr_pkg::*;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          take;
  sqrt_lane_t    lane_nxt;

  always_comb begin
    rem_sh        = {lane_in.rem[RW-3:0], lane_in.rad[31:30]};
    trial         = {(RW-34)'(0), lane_in.root, 2'b01};
    take          = rem_sh >= trial;
    lane_nxt.rem  = take ? rem_sh - trial : rem_sh;
    lane_nxt.root = {lane_in.root[30:0], take};
    lane_nxt.rad  = {lane_in.rad[29:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

/* design/fdr_skid.sv */
// Output register with a skid slot, so the pipeline's ready is registered.
module fdr_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fdr_pkg::out_item_t in_item,
  output logic               in_ready,
  output logic               out_valid,
  output fdr_pkg::out_item_t out_item,
  input  logic               out_ready
);
  import fdr_pkg::*;

  logic      out_valid_r;
  logic      skid_valid_r;
  out_item_t out_item_r;
  out_item_t skid_item_r;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_valid;
      end
    end else if (in_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_item_r <= skid_valid_r ? skid_item_r : in_item;
    end else if (in_valid && !skid_valid_r) begin
      skid_item_r <= in_item;
    end
  end

endmodule

/* design/fresnel_dielectric_reflectance.sv */
// Top level of the pipelined unpolarized Fresnel dielectric reflectance block.
//
//   channel | ports                              | contents
//   --------+------------------------------------+-----------------------------------------
//   input   | in_tvalid in_tready in_tdata[39:0]  | cos_incident [17:0], index_ratio [37:18]
//   result  | out_tvalid out_tready out_tdata     | reflectance [16:0]; out_tuser total_internal
//
// One item enters and one result leaves per cycle while the output is not stalled; the
// pipeline is three chains of 32 cells each (the sin^2 divider, the square root and the
// pair of amplitude-ratio dividers) plus the input, multiply and output stages.
// Reset (rst_n low at a clock edge) empties the pipeline and the output slots.
// A stalled result moves into a skid slot; the whole pipeline freezes only once that
// slot is full, and in_tready is a register output.
module fresnel_dielectric_reflectance (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: cos_incident (18, signed), index_ratio (20), zero pad (2).
  input  logic [fdr_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: reflectance (17), zero pad (7).
  output logic [fdr_pkg::OUT_DATA_W-1:0]  out_tdata,
  // Fields from bit 0: total_internal (1).
  output logic                            out_tuser
);
  import fdr_pkg::*;

  typedef struct packed {
    logic [16:0] c;
    logic [19:0] eta;
    logic        inv;
    logic        tir;
    logic [31:0] sinv;
  } side_a_t;

  typedef struct packed {
    logic [16:0] c;
    logic [19:0] eta;
    logic        tir;
    logic        full;
  } side_s_t;

  // The pipeline advances as a whole whenever the skid slot is free.
  logic pipe_en;
  assign in_tready = pipe_en;

  // Stage 1: clamp the cosine, take its magnitude, saturate the index.
  logic signed [COS_W-1:0] cs_in;
  logic [ETA_W-1:0]        eta_in;
  logic [16:0]             c_in;
  logic                    inv_in;

  always_comb begin
    logic signed [COS_W-1:0] cs_cl;
    cs_in  = $signed(in_tdata[COS_W-1:0]);
    eta_in = in_tdata[COS_W+ETA_W-1:COS_W];
    cs_cl  = cs_in;
    if (cs_in > $signed(COS_W'(1) << FRAC_BITS)) begin
      cs_cl = $signed(COS_W'(1) << FRAC_BITS);
    end else if (cs_in < -$signed(COS_W'(1) << FRAC_BITS)) begin
      cs_cl = -$signed(COS_W'(1) << FRAC_BITS);
    end
    inv_in = cs_cl[COS_W-1];
    c_in   = inv_in ? 17'(-cs_cl) : 17'(cs_cl);
    if (eta_in < (ETA_W'(1) << (FRAC_BITS - 2))) begin
      eta_in = ETA_W'(1) << (FRAC_BITS - 2);
    end
  end

  logic        v1_r, inv1_r;
  logic [16:0] c1_r;
  logic [19:0] eta1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c1_r   <= c_in;
      eta1_r <= eta_in;
      inv1_r <= inv_in;
    end
  end

  // Stage 2: S = 1 - c^2 in Q.32 and eta^2 in Q.32.
  logic        v2_r, inv2_r;
  logic [16:0] c2_r;
  logic [19:0] eta2_r;
  logic [32:0] s2_r;
  logic [39:0] esq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c2_r   <= c1_r;
      eta2_r <= eta1_r;
      inv2_r <= inv1_r;
      s2_r   <= (33'(1) << (2 * FRAC_BITS)) - 33'(34'(c1_r) * 34'(c1_r));
      esq2_r <= 40'(eta1_r) * 40'(eta1_r);
    end
  end

  // Chain A: sin^2 of the refracted angle by division on the direct side. The
  // inverted side multiplies instead; its partial products ride the first two cells.
  div_lane_t   lane_a [0:DIV_STEPS];
  side_a_t     side_a_r [1:DIV_STEPS];
  logic        va_r [1:DIV_STEPS];
  logic [52:0] pplo_r, pphi_r;
  logic [72:0] prod_a;

  assign lane_a[0].rem = DW'(s2_r);
  assign lane_a[0].den = DW'(esq2_r);
  assign lane_a[0].quo = '0;
  assign prod_a        = 73'(pplo_r) + (73'(pphi_r) << 20);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pplo_r <= 53'(s2_r) * 53'(esq2_r[19:0]);
      pphi_r <= 53'(s2_r) * 53'(esq2_r[39:20]);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_chain_a
    fdr_div_cell u_cell (
      .clk     (clk),
      .en      (pipe_en),
      .lane_in (lane_a[k]),
      .lane_r  (lane_a[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[k+1] <= 1'b0;
      end else if (pipe_en) begin
        va_r[k+1] <= (k == 0) ? v2_r : va_r[k];
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          side_a_r[1] <= '{c: c2_r, eta: eta2_r, inv: inv2_r,
                           tir: (40'(s2_r) >= esq2_r),
                           sinv: 32'd0};
        end
      end
    end else if (k == 1) begin : g_second
      // Inverted side: total reflection when S * eta^2 reaches one in Q.64.
      side_a_t side_a2_nxt;

      always_comb begin
        side_a2_nxt      = side_a_r[1];
        side_a2_nxt.sinv = prod_a[63:32];
        side_a2_nxt.tir  = side_a_r[1].inv ? (|prod_a[72:64]) : side_a_r[1].tir;
      end

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          side_a_r[2] <= side_a2_nxt;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          side_a_r[k+1] <= side_a_r[k];
        end
      end
    end
  end

  // Chain S: cosT = sqrt(1 - sin^2) in Q.32.
  logic [31:0] sin2_a;
  logic [32:0] t2_a;
  sqrt_lane_t  lane_s [0:SQRT_STEPS];
  side_s_t     side_s_r [1:SQRT_STEPS];
  logic        vs_r [1:SQRT_STEPS];

  assign sin2_a         = side_a_r[DIV_STEPS].inv ? side_a_r[DIV_STEPS].sinv
                                                  : lane_a[DIV_STEPS].quo[31:0];
  assign t2_a           = 33'h1_0000_0000 - 33'(sin2_a);
  assign lane_s[0].rem  = '0;
  assign lane_s[0].root = '0;
  assign lane_s[0].rad  = t2_a[31:0];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_chain_s
    fdr_sqrt_cell u_cell (
      .clk     (clk),
      .en      (pipe_en),
      .lane_in (lane_s[k]),
      .lane_r  (lane_s[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k+1] <= 1'b0;
      end else if (pipe_en) begin
        vs_r[k+1] <= (k == 0) ? va_r[DIV_STEPS] : vs_r[k];
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          side_s_r[1] <= '{c: side_a_r[DIV_STEPS].c, eta: side_a_r[DIV_STEPS].eta,
                           tir: side_a_r[DIV_STEPS].tir, full: t2_a[32]};
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          side_s_r[k+1] <= side_s_r[k];
        end
      end
    end
  end

  // Multiply stage: eta*c and eta*cosT.
  logic [32:0] t_s;
  logic        vm1_r, tirm1_r;
  logic [16:0] cm1_r;
  logic [32:0] tm1_r;
  logic [36:0] ecm1_r;
  logic [52:0] etm1_r;

  assign t_s = side_s_r[SQRT_STEPS].full ? 33'h1_0000_0000
                                         : 33'(lane_s[SQRT_STEPS].root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else if (pipe_en) begin
      vm1_r <= vs_r[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      tirm1_r <= side_s_r[SQRT_STEPS].tir;
      cm1_r   <= side_s_r[SQRT_STEPS].c;
      tm1_r   <= t_s;
      ecm1_r  <= 37'(side_s_r[SQRT_STEPS].eta) * 37'(side_s_r[SQRT_STEPS].c);
      etm1_r  <= 53'(side_s_r[SQRT_STEPS].eta) * 53'(t_s);
    end
  end

  // Numerators and denominators of the two amplitude ratios, all in Q.48.
  logic [53:0] ec54, tq54, cq54, et54;
  logic        vm2_r, tirm2_r;
  logic [53:0] n1_r, d1_r, n2_r, d2_r;

  assign ec54 = 54'(ecm1_r) << FRAC_BITS;
  assign tq54 = 54'(tm1_r) << FRAC_BITS;
  assign cq54 = 54'(cm1_r) << 32;
  assign et54 = 54'(etm1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else if (pipe_en) begin
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      tirm2_r <= tirm1_r;
      n1_r    <= (ec54 >= tq54) ? ec54 - tq54 : tq54 - ec54;
      d1_r    <= ec54 + tq54;
      n2_r    <= (cq54 >= et54) ? cq54 - et54 : et54 - cq54;
      d2_r    <= cq54 + et54;
    end
  end

  // Chain B: both ratios to Q.32, two lanes of cells side by side. The integer
  // quotient bit (a ratio of exactly one) is settled before the first cell.
  div_lane_t lane_p [0:DIV_STEPS];
  div_lane_t lane_q [0:DIV_STEPS];
  logic      vb_r [1:DIV_STEPS];
  logic      tirb_r [1:DIV_STEPS];
  logic      take_p, take_q;

  assign take_p        = n1_r >= d1_r;
  assign take_q        = n2_r >= d2_r;
  assign lane_p[0].rem = DW'(take_p ? n1_r - d1_r : n1_r);
  assign lane_p[0].den = DW'(d1_r);
  assign lane_p[0].quo = QW'(take_p);
  assign lane_q[0].rem = DW'(take_q ? n2_r - d2_r : n2_r);
  assign lane_q[0].den = DW'(d2_r);
  assign lane_q[0].quo = QW'(take_q);

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_chain_b
    fdr_div_cell u_cell_p (
      .clk     (clk),
      .en      (pipe_en),
      .lane_in (lane_p[k]),
      .lane_r  (lane_p[k+1])
    );

    fdr_div_cell u_cell_q (
      .clk     (clk),
      .en      (pipe_en),
      .lane_in (lane_q[k]),
      .lane_r  (lane_q[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vb_r[k+1] <= 1'b0;
      end else if (pipe_en) begin
        vb_r[k+1] <= (k == 0) ? vm2_r : vb_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        tirb_r[k+1] <= (k == 0) ? tirm2_r : tirb_r[k];
      end
    end
  end

  // Square both ratios, truncated to Q.32.
  logic [65:0] sqp, sqq;
  logic        vq_r, tirq_r;
  logic [32:0] sqp_r, sqq_r;

  assign sqp = 66'(lane_p[DIV_STEPS].quo) * 66'(lane_p[DIV_STEPS].quo);
  assign sqq = 66'(lane_q[DIV_STEPS].quo) * 66'(lane_q[DIV_STEPS].quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (pipe_en) begin
      vq_r <= vb_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      tirq_r <= tirb_r[DIV_STEPS];
      sqp_r  <= sqp[64:32];
      sqq_r  <= sqq[64:32];
    end
  end

  // Halve the sum and round to nearest, half up; total reflection forces one.
  logic [33:0] sum_q, rnd_q;
  out_item_t   item_q;
  out_item_t   item_out;

  always_comb begin
    sum_q       = 34'(sqp_r) + 34'(sqq_r);
    rnd_q       = sum_q + (34'(1) << (32 - FRAC_BITS));
    item_q.tir  = tirq_r;
    item_q.refl = tirq_r ? REFL_ONE : REFL_W'(rnd_q >> (33 - FRAC_BITS));
  end

  fdr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vq_r),
    .in_item   (item_q),
    .in_ready  (pipe_en),
    .out_valid (out_tvalid),
    .out_item  (item_out),
    .out_ready (out_tready)
  );

  assign out_tdata = OUT_DATA_W'(item_out.refl);
  assign out_tuser = item_out.tir;

  // A reported total internal reflection always carries a reflectance of one.
  a_tir_is_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[REFL_W-1:0] == REFL_ONE)
    else $error("total internal reflection without unit reflectance");

  // The reflectance never exceeds one.
  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[REFL_W-1:0] <= REFL_ONE)
    else $error("reflectance above one");

  // A frozen pipeline keeps the item waiting at its last stage.
  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en && vq_r |=> vq_r && $stable(item_q))
    else $error("last pipeline stage changed while frozen");

endmodule

/* tb/tb_fresnel_dielectric_reflectance.sv */
// Self-checking testbench for the Fresnel dielectric reflectance pipeline.
`timescale 1ns / 100ps

module tb_fresnel_dielectric_reflectance;
  import fdr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  // The end wait is longer than the pipeline latency, to give margin.
  localparam int FLUSH_CYCLES = 160;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  fresnel_dielectric_reflectance dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Expected reflectance results, oldest first.
  out_item_t pending_refl[$];
  int        error_count;
  int        sent_count;
  int        checked_count;
  int        tir_count;
  int        cycle_count;
  // Idling on both sides is switched off for the last part of the run.
  bit        idle_on;
  // Cycles left in a long receiver hold-off; counted down by the receiver process.
  int        hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Integer square root, floor, of a 64-bit value.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Ratio n/d in Q.32, truncated, then squared and truncated to Q.32.
  function automatic logic [63:0] ratio_squared(input logic [63:0] n, input logic [63:0] d);
    logic [127:0] r;
    logic [127:0] sq;
    r  = ({64'd0, n} << 32) / {64'd0, d};
    sq = (r * r) >> 32;
    return sq[63:0];
  endfunction

  // Computes the expected reflectance for one cosine / index pair.
  function automatic out_item_t fresnel_reflectance(input logic signed [COS_W-1:0] cos_raw,
                                                    input logic [ETA_W-1:0] eta_raw);
    out_item_t     res;
    logic signed [31:0] cs;
    logic          flipped;
    logic [63:0]   c, eta, s_term, eta_sq, sin2, t2, t, c32, ec, et, cq, tq;
    logic [63:0]   n1, d1, n2, d2, sum;
    logic [127:0]  wide;
    logic          tir;
    cs = cos_raw;
    if (cs > (32'sd1 <<< FRAC_BITS)) cs = 32'sd1 <<< FRAC_BITS;
    if (cs < -(32'sd1 <<< FRAC_BITS)) cs = -(32'sd1 <<< FRAC_BITS);
    flipped = cs < 0;
    c = flipped ? 64'(-cs) : 64'(cs);
    eta = eta_raw;
    // Indices below a quarter saturate to 0.25.
    if (eta < (64'd1 << (FRAC_BITS - 2))) eta = 64'd1 << (FRAC_BITS - 2);
    s_term = (64'd1 << (2 * FRAC_BITS)) - c * c;
    eta_sq = eta * eta;
    tir = 1'b0;
    sin2 = 64'd0;
    if (!flipped) begin
      if (s_term >= eta_sq) tir = 1'b1;
      else begin
        wide = ({64'd0, s_term} << 32) / {64'd0, eta_sq};
        sin2 = wide[63:0];
      end
    end else begin
      // From the far side the index is inverted, so sin^2 scales by eta^2.
      wide = ({64'd0, s_term} * {64'd0, eta_sq}) >> (4 * FRAC_BITS - 32);
      if (wide >= (128'd1 << 32)) tir = 1'b1;
      else sin2 = wide[63:0];
    end
    if (tir) begin
      res.refl = REFL_ONE;
      res.tir  = 1'b1;
      return res;
    end
    t2 = (64'd1 << 32) - sin2;
    t  = (t2 == (64'd1 << 32)) ? t2 : floor_sqrt(t2 << 32);
    c32 = c << (32 - FRAC_BITS);
    ec = eta * c32;
    et = eta * t;
    cq = c32 << FRAC_BITS;
    tq = t << FRAC_BITS;
    n1 = (ec >= tq) ? ec - tq : tq - ec;
    d1 = ec + tq;
    n2 = (cq >= et) ? cq - et : et - cq;
    d2 = cq + et;
    sum = ratio_squared(n1, d1) + ratio_squared(n2, d2);
    sum = (sum + (64'd1 << (32 - FRAC_BITS))) >> (33 - FRAC_BITS);
    res.refl = sum[REFL_W-1:0];
    res.tir  = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d: %s got %0d expected %0d", checked_count, what, got, want);
    error_count++;
  endtask

  // Offers one item, with an occasional random gap first, and waits for the transfer.
  task automatic send_item(input logic signed [COS_W-1:0] cos_raw,
                           input logic [ETA_W-1:0] eta_raw);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, eta_raw, cos_raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_refl.push_back(fresnel_reflectance(cos_raw, eta_raw));
    sent_count++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_refl.size() != 0) @(posedge clk);
  endtask

  // Random cosine: mostly in range, sometimes any 18-bit pattern to hit clamping.
  function automatic logic [COS_W-1:0] random_cos();
    if ($urandom_range(0, 7) == 0) return COS_W'($urandom);
    return COS_W'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  // Random index: mostly between 0.25 and 3.0, sometimes any 20-bit pattern.
  function automatic logic [ETA_W-1:0] random_eta();
    case ($urandom_range(0, 3))
      0:       return ETA_W'($urandom);
      1:       return ETA_W'($urandom_range(16384, 65536));
      default: return ETA_W'($urandom_range(65536, 196608));
    endcase
  endfunction

  // Extremes of both fields, clamping, saturation, zero cosine and both TIR sides.
  task automatic test_directed();
    send_item(18'sd65536, 20'd98304);
    send_item(-18'sd65536, 20'd98304);
    send_item(18'sd0, 20'd98304);
    send_item(18'sd0, 20'd65536);
    send_item(18'sd1, 20'd1048575);
    send_item(-18'sd1, 20'd1048575);
    send_item(18'sd131071, 20'd16384);
    send_item(-18'sd131072, 20'd16384);
    send_item(18'sd65536, 20'd0);
    send_item(-18'sd65536, 20'd1);
    send_item(18'sd1000, 20'd32768);
    send_item(-18'sd1000, 20'd98304);
    send_item(-18'sd60000, 20'd70000);
    send_item(18'sd46341, 20'd46341);
    send_item(-18'sd46341, 20'd92682);
    send_item(18'sd65535, 20'd65536);
    send_item(-18'sd65535, 20'd65536);
    send_item(18'sd32768, 20'd1048575);
    send_item(-18'sd32768, 20'd16383);
    send_item(18'sd43690, 20'd699050);
    stop_sending();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_item(random_cos(), random_eta());
    stop_sending();
  endtask

  // The receiver holds off while items keep coming, so the pipeline fills and stalls.
  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (200) send_item(random_cos(), random_eta());
    stop_sending();
  endtask

  // Result receiver: random bursts of stall, or a long hold-off when one is asked.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Checks every result transfer against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_refl.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        want = pending_refl.pop_front();
        if (out_tdata[REFL_W-1:0] !== want.refl)
          report_mismatch("reflectance", out_tdata[REFL_W-1:0], want.refl);
        if (out_tuser !== want.tir)
          report_mismatch("total_internal", out_tuser, want.tir);
        if (want.tir) tir_count++;
      end
      checked_count++;
    end
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_refl.size());
      $display("fresnel_dielectric_reflectance verification failed");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    sent_count    = 0;
    checked_count = 0;
    tir_count     = 0;
    cycle_count   = 0;
    hold_cycles   = 0;
    idle_on       = 1'b1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(300);
    // The sender pauses here until every expected result has come back.
    wait_drained();
    test_backpressure();
    test_random(250);
    idle_on = 1'b0;
    test_random(130);

    wait_drained();
    repeat (FLUSH_CYCLES) @(posedge clk);
    $display("Sent %0d items, checked %0d results (%0d total internal reflection).",
             sent_count, checked_count, tir_count);
    $display("Covered clamping, index saturation, both sides, stalls and a full pipeline.");
    if (error_count == 0 && pending_refl.size() == 0) begin
      $display("fresnel_dielectric_reflectance verification clean");
    end else begin
      $display("fresnel_dielectric_reflectance verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/fdr_pkg.sv
design/fdr_div_cell.sv
design/fdr_sqrt_cell.sv
design/fdr_skid.sv
design/fresnel_dielectric_reflectance.sv
tb/tb_fresnel_dielectric_reflectance.sv
